// File: sv/shc_pkg.sv
// Package: constants, types and helper functions for the custom-constant SHA-256 style hash.
package shc_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ChainDepth = 8;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned Rounds = 64;
   localparam int unsigned LengthAt = 56;

   localparam logic [7:0] PadByte = 8'h80;

   typedef logic [31:0] word_type;

   localparam word_type InitWords [ChainDepth] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'hbe4ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h50accd19
   };

   localparam word_type RoundKeys [Rounds] = '{
      32'h21370680, 32'h116ceec0, 32'h11ab5a00, 32'h1f246300,
      32'h1ea34703, 32'h81a7e0c5, 32'hce733073, 32'hb00bf00d,
      32'hdeadbeef, 32'h0badc0de, 32'hcafebabe, 32'hfaceb00c,
      32'h1337c0de, 32'h600d1dea, 32'hf005ba11, 32'h12345678,
      32'h8badf00d, 32'hd15ea5e0, 32'hc0ffee00, 32'hbaaaaaad,
      32'hfeedf00d, 32'h0d15ea5e, 32'hfadebabe, 32'ha11dead0,
      32'hfee1dead, 32'h0ff1ce00, 32'hba5eba11, 32'hdeadc0de,
      32'habad1dea, 32'hfacade00, 32'hdeafbeef, 32'hbeefcace,
      32'habcddcba, 32'h600dc0de, 32'h10aded00, 32'hc01df00d,
      32'h900dbeef, 32'hbeadedfa, 32'hbed0babe, 32'hdeadfa11,
      32'hc01a1ab5, 32'hf1ee1eaf, 32'hd0d0caca, 32'h404b00b5,
      32'habcafeed, 32'hdead2bad, 32'h777b00b5, 32'h5ca1ab1e,
      32'hdefec8ed, 32'hfac3c0de, 32'hd15ea5ed, 32'hbaaaaaaa,
      32'hf0e1f0e1, 32'hfadefade, 32'hc0deba5e, 32'h50fababe,
      32'hbabeface, 32'ha5a5a5a5, 32'hbeefdead, 32'h7e57e57e,
      32'hf007ba11, 32'hca11ab1e, 32'hd0ff1ce0, 32'hbadc0ffe
   };

   // byte source selection for the block buffer write
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   // controller -> datapath
   typedef struct packed {
      logic         write_byte;
      byte_src_type byte_src;
      logic [7:0]   data_byte;
      logic         count_bits;
      logic         snap_len;
      logic         round_start;
      logic         round_step;
      logic         chain_add;
      logic         chain_init;
      logic         out_load;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } dp_status_type;

   function automatic word_type rotr(input word_type v, input int unsigned n);
      rotr = (v >> n) | (v << (WordWidth - n));
   endfunction

endpackage

// File: sv/shc_stream_if.sv
// Interface: valid/ready channel carrying a generic payload.
interface shc_stream_if #(
   parameter type payload_type = logic
) (
   input logic clock
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/shc_ram.sv
// Generic single-port-write, registered-read RAM.
module shc_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/shc_datapath.sv
// Datapath: block buffer, schedule, round registers, chaining words and length.
module shc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  shc_pkg::dp_cmd_type   cmd,
   output shc_pkg::dp_status_type status,
   input  logic [2:0]            out_sel,
   output shc_pkg::word_type     out_word
);
   import shc_pkg::*;

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff;
   logic [5:0]  round_ff, round_in;
   word_type    chain_ff [ChainDepth];
   word_type    out_ff [ChainDepth];
   word_type    sched_ff [16];
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;

   logic [7:0]  wr_data;
   logic [31:0] rd_word;
   logic [3:0]  rd_addr;
   logic [2:0]  len_sel;

   // bytes are stored as 16 words of 4 bytes; a word is assembled by byte lanes
   logic [3:0]  lane_we;
   logic [7:0]  lane_rd [4];

   always_comb begin
      len_sel = fill_ff[2:0];
      case (cmd.byte_src)
         SRC_DATA: wr_data = cmd.data_byte;
         SRC_PAD:  wr_data = PadByte;
         SRC_ZERO: wr_data = 8'h00;
         SRC_LEN:  wr_data = len_ff[8'(7 - len_sel) * 8 +: 8];
         default:  wr_data = 8'h00;
      endcase
   end

   genvar gl;
   generate
      for (gl = 0; gl < 4; gl++) begin : g_lane
         assign lane_we[gl] = cmd.write_byte && (fill_ff[1:0] == 2'(3 - gl));
         shc_ram #(.Width(8), .Depth(16)) u_lane (
            .clock  (clock),
            .wr_en  (lane_we[gl]),
            .wr_addr(fill_ff[5:2]),
            .wr_data(wr_data),
            .rd_addr(rd_addr),
            .rd_data(lane_rd[gl])
         );
      end
   endgenerate

   assign rd_word = {lane_rd[3], lane_rd[2], lane_rd[1], lane_rd[0]};

   // read one ahead: round r needs word r during round r, issued in previous cycle
   always_comb begin
      if (cmd.round_start) begin
         rd_addr = 4'd0;
      end else begin
         rd_addr = 4'(round_ff + 6'd1);
      end
   end

   word_type w15, w2, s0, s1, w_new, w_cur, t1, t2;
   always_comb begin
      w15 = sched_ff[1];
      w2  = sched_ff[14];
      s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      w_new = sched_ff[0] + s0 + sched_ff[9] + s1;
      w_cur = (round_ff < 6'd16) ? rd_word : w_new;
      t1 = h_ff + (rotr(e_ff, 6) ^ rotr(e_ff, 11) ^ rotr(e_ff, 25)) +
           ((e_ff & f_ff) ^ (~e_ff & g_ff)) + RoundKeys[round_ff] + w_cur;
      t2 = (rotr(a_ff, 2) ^ rotr(a_ff, 13) ^ rotr(a_ff, 22)) +
           ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.write_byte) begin
         fill_in = fill_ff + 6'd1;
      end
      bits_in = bits_ff;
      if (cmd.chain_init) begin
         bits_in = '0;
      end else if (cmd.count_bits) begin
         bits_in = bits_ff + 64'd8;
      end
      round_in = round_ff;
      if (cmd.round_start) begin
         round_in = '0;
      end else if (cmd.round_step) begin
         round_in = round_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         for (int i = 0; i < ChainDepth; i++) begin
            chain_ff[i] <= InitWords[i];
         end
      end else begin
         fill_ff  <= cmd.chain_init ? 6'd0 : fill_in;
         bits_ff  <= bits_in;
         round_ff <= round_in;
         if (cmd.chain_init) begin
            for (int i = 0; i < ChainDepth; i++) begin
               chain_ff[i] <= InitWords[i];
            end
         end else if (cmd.chain_add) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
            chain_ff[4] <= chain_ff[4] + e_ff;
            chain_ff[5] <= chain_ff[5] + f_ff;
            chain_ff[6] <= chain_ff[6] + g_ff;
            chain_ff[7] <= chain_ff[7] + h_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap_len) begin
         len_ff <= bits_in;
      end
      if (cmd.out_load) begin
         for (int i = 0; i < ChainDepth; i++) begin
            out_ff[i] <= chain_ff[i];
         end
      end
      if (cmd.round_start) begin
         a_ff <= chain_ff[0]; b_ff <= chain_ff[1];
         c_ff <= chain_ff[2]; d_ff <= chain_ff[3];
         e_ff <= chain_ff[4]; f_ff <= chain_ff[5];
         g_ff <= chain_ff[6]; h_ff <= chain_ff[7];
      end else if (cmd.round_step) begin
         h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
         d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= w_cur;
      end
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == 6'(Rounds - 1));
   assign out_word          = out_ff[out_sel];
endmodule

// File: sv/shc_control.sv
// Controller: sequences byte loads, padding, compression rounds and digest output.
module shc_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_data,
   input  logic                   in_has,
   input  logic                   in_last,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [2:0]             out_index,
   output shc_pkg::dp_cmd_type    cmd,
   input  shc_pkg::dp_status_type status
);
   import shc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic       final_ff, final_in;
   logic       padded_ff, padded_in;
   logic [2:0] index_ff, index_in;

   // set once the length bytes have gone into the buffer during padding; cleared while idle
   logic len_written_ff;
   // pad byte landed at or past LengthAt: length goes into the following block
   logic spill_ff;

   logic accept, byte_full;

   assign accept    = in_valid && in_ready;
   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT) && padded_ff;
   assign out_index = index_ff;
   assign byte_full = (status.fill == 6'(BlockBytes - 1));

   always_comb begin
      state_in  = state_ff;
      final_in  = final_ff;
      padded_in = padded_ff;
      index_in  = index_ff;
      cmd = '0;
      cmd.byte_src  = SRC_DATA;
      cmd.data_byte = in_data;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               final_in  = in_last;
               padded_in = 1'b0;
               cmd.count_bits = in_has;
               cmd.snap_len   = 1'b1;
               if (in_has) begin
                  cmd.write_byte = 1'b1;
                  if (byte_full) begin
                     state_in = ST_PRIME;
                  end else if (in_last) begin
                     state_in = ST_PAD;
                  end
               end else if (in_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.write_byte = 1'b1;
            if (!padded_ff) begin
               cmd.byte_src = SRC_PAD;
               padded_in = 1'b1;
            end else if (status.fill >= 6'(LengthAt) && !spill_ff) begin
               cmd.byte_src = SRC_LEN;
            end else begin
               cmd.byte_src = SRC_ZERO;
            end
            if (byte_full) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.round_start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.chain_add = 1'b1;
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (padded_ff && status.fill == 6'd0 && len_written_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (index_ff == 3'd0 && !padded_ff) begin
               cmd.out_load = 1'b1;
               cmd.chain_init = 1'b1;
               padded_in = 1'b1;
            end
            if (out_ready && padded_ff) begin
               index_in = index_ff + 3'd1;
               if (index_ff == 3'(ChainDepth - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         final_ff       <= 1'b0;
         padded_ff      <= 1'b0;
         index_ff       <= '0;
         len_written_ff <= 1'b0;
         spill_ff       <= 1'b0;
      end else begin
         state_ff  <= state_in;
         final_ff  <= final_in;
         index_ff  <= index_in;
         if (state_ff == ST_IDLE) begin
            len_written_ff <= 1'b0;
         end else if (state_ff == ST_PAD && cmd.byte_src == SRC_LEN) begin
            len_written_ff <= 1'b1;
         end
         if (state_ff == ST_IDLE || state_ff == ST_ADD) begin
            spill_ff <= 1'b0;
         end else if (state_ff == ST_PAD && !padded_ff && status.fill >= 6'(LengthAt)) begin
            spill_ff <= 1'b1;
         end
         if (state_ff == ST_ADD && final_ff && padded_ff && len_written_ff) begin
            padded_ff <= 1'b0;
         end else begin
            padded_ff <= padded_in;
         end
      end
   end
endmodule

// File: sv/sha256_style_hash_custom_constants.sv
// Top level: streaming SHA-256 style hash with custom round constants and initial words.
// Usage:
//   req channel: one word per message byte (data_byte, has_byte, last). A word with
//   last set ends the message; an empty message is a final word with has_byte clear.
//   rsp channel: eight words per message (digest_word, word_index 0..7, last_word on 7).
// Timing:
//   A byte that does not complete a block is taken with the controller staying idle. A word
//   that fills the 64-byte buffer starts one compression: a prime step, 64 rounds and an add
//   step in the single round unit; no new byte is taken until the compression ends.
//   A final word adds padding bytes at one per cycle outside compressions (at most 72, when
//   the 0x80 byte lands at offset 56 and the length spills into a second block) plus one or
//   two compressions, then a load step, then one digest word per accepted rsp transfer.
//   req_ready is low from a final word until the eighth digest word is taken.
// Reset:
//   reset is synchronous, active high; it restores the initial chaining words and
//   clears the fill count and bit length. Buffer contents are not cleared.
// Stall:
//   while rsp_ready is low the current digest word holds and no input is taken.
module sha256_style_hash_custom_constants (
   input logic clock,
   input logic reset,
   shc_stream_if.sink   req,
   shc_stream_if.source rsp
);
   import shc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    out_index;
   word_type      out_word;

   shc_control u_control (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_data  (req.payload.data_byte),
      .in_has   (req.payload.has_byte),
      .in_last  (req.payload.last),
      .out_valid(rsp.valid),
      .out_ready(rsp.ready),
      .out_index(out_index),
      .cmd      (cmd),
      .status   (status)
   );

   shc_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .out_sel (out_index),
      .out_word(out_word)
   );

   assign rsp.payload.digest_word = out_word;
   assign rsp.payload.word_index  = out_index;
   assign rsp.payload.last_word   = (out_index == 3'(ChainDepth - 1));

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("input taken while digest pending");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && out_index != 3'd7) |=> rsp.valid)
      else $error("digest words interrupted");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.round_step && status.round_last) |=> !cmd.round_step)
      else $error("rounds ran past the last");
endmodule

// File: tb/tb.sv
// Testbench: random byte streams into the custom-constant SHA-256 style hash, digests checked.
module tb;
   import shc_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_word_type;

   class digest_scoreboard;
      word_type chain [ChainDepth];
      logic [7:0] buffer [BlockBytes];
      int unsigned fill;
      logic [63:0] bit_count;
      rsp_word_type digest_q [$];
      int errors;
      int messages;
      int words_seen;

      function new();
         errors = 0;
         messages = 0;
         words_seen = 0;
         foreach (buffer[i]) buffer[i] = 8'h00;
         restart();
      endfunction

      function void restart();
         chain = InitWords;
         fill = 0;
         bit_count = '0;
      endfunction

      function word_type ror(word_type v, int n);
         return (v >> n) | (v << (32 - n));
      endfunction

      function void compress();
         word_type w [16];
         word_type a, b, c, d, e, f, g, h, t1, t2, s0, s1, wj;
         for (int j = 0; j < 16; j++)
            w[j] = {buffer[4*j], buffer[4*j+1], buffer[4*j+2], buffer[4*j+3]};
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int j = 0; j < Rounds; j++) begin
            if (j < 16) begin
               wj = w[j];
            end else begin
               s0 = ror(w[(j-15)%16], 7) ^ ror(w[(j-15)%16], 18) ^ (w[(j-15)%16] >> 3);
               s1 = ror(w[(j-2)%16], 17) ^ ror(w[(j-2)%16], 19) ^ (w[(j-2)%16] >> 10);
               wj = w[j%16] + s0 + w[(j-7)%16] + s1;
               w[j%16] = wj;
            end
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + RoundKeys[j] + wj;
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      function void absorb(logic [7:0] value);
         buffer[fill] = value;
         fill++;
         if (fill == BlockBytes) begin
            compress();
            fill = 0;
         end
      endfunction

      function void note_input(req_word_type r);
         logic [63:0] len;
         rsp_word_type x;
         if (r.has_byte) begin
            absorb(r.data_byte);
            bit_count += 64'd8;
         end
         if (r.last) begin
            len = bit_count;
            absorb(PadByte);
            while (fill != LengthAt) absorb(8'h00);
            for (int i = 0; i < 8; i++) absorb(len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
               x.digest_word = chain[i];
               x.word_index = 3'(i);
               x.last_word = (i == 7);
               digest_q = {digest_q, x};
            end
            messages++;
            restart();
         end
      endfunction

      function void check_result(rsp_word_type r);
         rsp_word_type x;
         words_seen++;
         if (digest_q.size() == 0) begin
            $error("unexpected digest word %h", r.digest_word);
            errors++;
            return;
         end
         x = digest_q.pop_front();
         if (r.digest_word !== x.digest_word) begin
            $error("digest_word: expected %h actual %h", x.digest_word, r.digest_word);
            errors++;
         end
         if (r.word_index !== x.word_index) begin
            $error("word_index: expected %0d actual %0d", x.word_index, r.word_index);
            errors++;
         end
         if (r.last_word !== x.last_word) begin
            $error("last_word: expected %0d actual %0d", x.last_word, r.last_word);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #1 clock = ~clock;

   shc_stream_if #(.payload_type(req_word_type)) req_ch (.clock(clock));
   shc_stream_if #(.payload_type(rsp_word_type)) rsp_ch (.clock(clock));

   sha256_style_hash_custom_constants u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   digest_scoreboard sb = new();
   int idle_cycles = 0;
   int item_count = 0;
   int burst_left = 0;
   bit hold_request = 0;

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_input(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 20000) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("sha256_style_hash_custom_constants: mismatch");
            $finish;
         end
      end
   end

   // receiver stall pattern, with one long hold on request
   initial begin
      int mode;
      int hold;
      mode = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0 && hold_request) begin
            hold = 400;
            hold_request = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 0;
         end else begin
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
               0: rsp_ch.ready <= 1;
               1: rsp_ch.ready <= $urandom_range(0, 1);
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_word(logic [7:0] value, logic has, logic fin);
      req_word_type w;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         repeat ($urandom_range(0, 8)) begin
            @(negedge clock);
            req_ch.valid <= 0;
         end
      end
      burst_left--;
      w.data_byte = value;
      w.has_byte = has;
      w.last = fin;
      @(negedge clock);
      req_ch.valid <= 1;
      req_ch.payload <= w;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_message(int len, bit end_with_byte, bit noise);
      for (int i = 0; i < len; i++) begin
         if (noise && $urandom_range(0, 15) == 0)
            send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, (end_with_byte && i == len - 1));
         item_count++;
      end
      if (!end_with_byte || len == 0) begin
         send_word(8'($urandom), 1'b0, 1'b1);
         item_count++;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 0;
      burst_left = 0;
      do @(posedge clock); while (sb.digest_q.size() != 0);
   endtask

   initial begin
      int len;
      int pick;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // empty message, single bytes at both extremes, idle word, final without byte
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h5a, 1'b0, 1'b0);
      send_word(8'ha5, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h3c, 1'b1, 1'b0);
      send_word(8'hc3, 1'b0, 1'b1);
      item_count += 8;
      drain();
      hold_request = 1;
      send_message(3, 1, 0);
      send_message(10, 0, 0);
      drain();
      while (item_count < 330) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) len = $urandom_range(0, 20);
         else if (pick < 9) len = $urandom_range(52, 66);
         else len = $urandom_range(115, 130);
         send_message(len, $urandom_range(0, 1), 1);
         if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
      repeat (300) @(posedge clock);
      $display("%0d messages, %0d input words, %0d digest words checked",
               sb.messages, item_count, sb.words_seen);
      $display("lengths around block and padding boundaries, long output stall included");
      if (sb.errors == 0 && sb.digest_q.size() == 0)
         $display("sha256_style_hash_custom_constants: match");
      else
         $display("sha256_style_hash_custom_constants: mismatch");
      $finish;
   end
endmodule
